>>> src/lfhp_pkg.sv
// Package for the LED frame header parser: parse phases, event kinds,
// result record and protocol constants. No dependencies.
package lfhp_pkg;

    localparam int unsigned LED_COUNT    = 256;
    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned PREFIX_BYTES = 6;

    localparam logic [7:0] CHECK_SEED   = 8'h55;
    localparam logic [7:0] COUNT_RADIX  = 8'd250;
    localparam logic [7:0] EFFECT_MAX   = 8'd13;

    // Header byte positions that carry fields
    localparam logic [4:0] HDR_COUNT_LOW  = 5'd1;
    localparam logic [4:0] HDR_COUNT_HIGH = 5'd2;
    localparam logic [4:0] HDR_BRIGHTNESS = 5'd3;
    localparam logic [4:0] HDR_EFFECT     = 5'd7;
    localparam logic [4:0] HDR_CHECK_POS  = 5'(HEADER_BYTES - 1);

    localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_BYTES - 1);
    localparam logic [15:0] LAST_PIXEL_INDEX = 16'(LED_COUNT - 1);

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_PIXELS = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_HEADER    = 2'd0,
        EV_PIXEL     = 2'd1,
        EV_BAD_CHECK = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] led_count;
        logic [7:0]  brightness_level;
        logic [7:0]  effect_code;
        logic [3:0]  effect_class;
        logic [15:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
    } result_t;

    function automatic logic [7:0] prefix_byte(input logic [2:0] pos);
        logic [7:0] b;
        begin
            unique case (pos)
                3'd0: b = 8'h44;    // D
                3'd1: b = 8'h50;    // P
                3'd2: b = 8'h73;    // s
                3'd3: b = 8'h6F;    // o
                3'd4: b = 8'h66;    // f
                3'd5: b = 8'h74;    // t
                default: b = 8'h44;
            endcase
            return b;
        end
    endfunction

endpackage

>>> src/lfhp_core.sv
// Parser state and per-byte decode for the LED frame header parser.
// Depends on lfhp_pkg.
module lfhp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output lfhp_pkg::result_t res
);
    import lfhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  prefix_pos_reg, prefix_pos_next;
    logic [4:0]  header_pos_reg, header_pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  count_low_reg, count_low_next;
    logic [7:0]  count_high_reg, count_high_next;
    logic [7:0]  bright_hold_reg, bright_hold_next;
    logic [7:0]  effect_hold_reg, effect_hold_next;
    logic [7:0]  bright_now_reg, bright_now_next;
    logic [7:0]  effect_use_reg, effect_use_next;
    logic [3:0]  effect_class_reg, effect_class_next;
    logic [15:0] pixel_cnt_reg, pixel_cnt_next;
    logic [1:0]  byte_in_pix_reg, byte_in_pix_next;
    logic [7:0]  col0_reg, col0_next;
    logic [7:0]  col1_reg, col1_next;

    logic [15:0] count;
    logic        check_ok;
    logic        prefix_hit;
    logic        last_pix;

    assign count      = 16'(count_low_reg) + 16'(count_high_reg) * 16'(COUNT_RADIX) + 16'd1;
    assign check_ok   = (rx_byte == (xor_reg ^ CHECK_SEED));
    assign prefix_hit = (rx_byte == prefix_byte(prefix_pos_reg));
    assign last_pix   = (pixel_cnt_reg >= LAST_PIXEL_INDEX);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                if (header_pos_reg == HDR_CHECK_POS) begin
                    if (check_ok && count == 16'(LED_COUNT)) begin
                        phase_next = PH_PIXELS;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_PIXELS: begin
                if (byte_in_pix_reg == 2'd2 && last_pix) begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                if (prefix_hit && prefix_pos_reg == PREFIX_LAST) begin
                    phase_next = PH_HEADER;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // Datapath updates and result
    always_comb begin
        prefix_pos_next   = prefix_pos_reg;
        header_pos_next   = header_pos_reg;
        xor_next          = xor_reg;
        count_low_next    = count_low_reg;
        count_high_next   = count_high_reg;
        bright_hold_next  = bright_hold_reg;
        effect_hold_next  = effect_hold_reg;
        bright_now_next   = bright_now_reg;
        effect_use_next   = effect_use_reg;
        effect_class_next = effect_class_reg;
        pixel_cnt_next    = pixel_cnt_reg;
        byte_in_pix_next  = byte_in_pix_reg;
        col0_next         = col0_reg;
        col1_next         = col1_reg;
        res_valid         = 1'b0;
        res               = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (header_pos_reg != HDR_CHECK_POS) begin
                    xor_next        = xor_reg ^ rx_byte;
                    header_pos_next = header_pos_reg + 5'd1;
                    if (header_pos_reg == HDR_COUNT_LOW)  count_low_next   = rx_byte;
                    if (header_pos_reg == HDR_COUNT_HIGH) count_high_next  = rx_byte;
                    if (header_pos_reg == HDR_BRIGHTNESS) bright_hold_next = rx_byte;
                    if (header_pos_reg == HDR_EFFECT)     effect_hold_next = rx_byte;
                end else begin
                    header_pos_next = '0;
                    xor_next        = '0;
                    res_valid       = 1'b1;
                    if (check_ok) begin
                        bright_now_next = bright_hold_reg;
                        if (effect_hold_reg != 8'd0 && effect_hold_reg != effect_use_reg) begin
                            effect_use_next = effect_hold_reg;
                            case (effect_hold_reg) inside
                                [8'd1:8'd5]:       effect_class_next = 4'd0;
                                [8'd6:EFFECT_MAX]: effect_class_next = 4'(effect_hold_reg - 8'd5);
                                default:           effect_class_next = effect_class_reg;
                            endcase
                        end
                        if (count == 16'(LED_COUNT)) begin
                            pixel_cnt_next   = '0;
                            byte_in_pix_next = '0;
                        end
                        res.event_kind = EV_HEADER;
                    end else begin
                        res.event_kind = EV_BAD_CHECK;
                    end
                    res.led_count = count;
                end
            end
            PH_PIXELS: begin
                if (byte_in_pix_reg == 2'd0) begin
                    col0_next        = rx_byte;
                    byte_in_pix_next = 2'd1;
                end else if (byte_in_pix_reg == 2'd1) begin
                    col1_next        = rx_byte;
                    byte_in_pix_next = 2'd2;
                end else begin
                    byte_in_pix_next = '0;
                    res_valid        = 1'b1;
                    res.event_kind   = EV_PIXEL;
                    res.led_count    = 16'(LED_COUNT);
                    res.pixel_index  = pixel_cnt_reg;
                    res.red          = col0_reg;
                    res.green        = col1_reg;
                    res.blue         = rx_byte;
                    res.last_pixel   = last_pix;
                    pixel_cnt_next   = last_pix ? 16'd0 : pixel_cnt_reg + 16'd1;
                end
            end
            default: begin
                // a mismatching byte restarts the hunt and is not rechecked
                if (prefix_hit && prefix_pos_reg != PREFIX_LAST) begin
                    prefix_pos_next = prefix_pos_reg + 3'd1;
                end else begin
                    prefix_pos_next = '0;
                end
                if (prefix_hit && prefix_pos_reg == PREFIX_LAST) begin
                    header_pos_next = '0;
                    xor_next        = '0;
                end
            end
        endcase

        res.brightness_level = bright_now_next;
        res.effect_code      = effect_use_next;
        res.effect_class     = effect_class_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            prefix_pos_reg   <= '0;
            header_pos_reg   <= '0;
            xor_reg          <= '0;
            bright_now_reg   <= '0;
            effect_use_reg   <= '0;
            effect_class_reg <= '0;
            pixel_cnt_reg    <= '0;
            byte_in_pix_reg  <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            prefix_pos_reg   <= prefix_pos_next;
            header_pos_reg   <= header_pos_next;
            xor_reg          <= xor_next;
            bright_now_reg   <= bright_now_next;
            effect_use_reg   <= effect_use_next;
            effect_class_reg <= effect_class_next;
            pixel_cnt_reg    <= pixel_cnt_next;
            byte_in_pix_reg  <= byte_in_pix_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            count_low_reg   <= count_low_next;
            count_high_reg  <= count_high_next;
            bright_hold_reg <= bright_hold_next;
            effect_hold_reg <= effect_hold_next;
            col0_reg        <= col0_next;
            col1_reg        <= col1_next;
        end
    end

endmodule

>>> src/led_frame_header_parser.sv
// LED frame header parser top level: input byte register, parser core,
// result register. Depends on lfhp_pkg and lfhp_core.
//
// Usage: feed received serial bytes on the s_ channel, one per transaction
// (s_tdata[7:0]). The block hunts for the prefix "DPsoft", gathers a 20-byte
// header and checks its XOR checksum, then forwards the pixel bytes of a
// matching frame as RGB triples. Each header ends in one m_ transaction
// (m_tuser = header accepted or checksum mismatch); each pixel triple ends in
// one m_ transaction (m_tuser = pixel), with m_tlast set on the frame's final
// pixel. Prefix bytes and the other header and pixel bytes give no result.
// An accepted byte goes to the input register, its result to the result
// register. Throughput: one byte per cycle unless m_tready stalls results,
// set by the combinational decode between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to prefix hunting with brightness, effect and effect class zero.
// When the receiver holds m_tready low, the result register holds its
// transaction, the input register fills and s_tready drops until m_tready
// returns; no byte or result is lost.
module led_frame_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [15:0] led_count, [23:16] brightness_level,
                                    // [31:24] effect_code, [35:32] effect_class,
                                    // [51:36] pixel_index, [59:52] red,
                                    // [67:60] green, [75:68] blue, [79:76] zero
    output logic [1:0]  m_tuser,    // [1:0] event_kind
    output logic        m_tlast     // last_pixel
);
    import lfhp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        out_free;
    logic        advance;
    logic        core_valid;
    result_t     core_res;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    lfhp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
        end
        if (out_free) begin
            out_valid_next = advance && core_valid;
            out_next       = core_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tlast  = out_reg.last_pixel;
    assign m_tdata  = {4'd0, out_reg.blue, out_reg.green, out_reg.red,
                       out_reg.pixel_index, out_reg.effect_class,
                       out_reg.effect_code, out_reg.brightness_level,
                       out_reg.led_count};

    // hold the buffered byte while the result side is stalled
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost while stalled");

    a_pixel_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_PIXEL |-> m_tdata[15:0] == 16'(LED_COUNT))
        else $error("pixel event with wrong led count");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == EV_PIXEL)
        else $error("last flag on a header event");

    a_header_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_PIXEL |-> m_tdata[75:36] == 40'd0)
        else $error("header event carries pixel data");

    a_no_kind3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined event kind emitted");

endmodule
